/* rtl/core/wffs_pkg.sv */
// Shared types, constants and helpers of the weighted fair frame scheduler.
package wffs_pkg;

	localparam int CLIENTS     = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int COST_UNIT   = 3600;

	localparam int CIW  = $clog2(CLIENTS);
	localparam int CNTW = $clog2(CLIENTS + 1);
	localparam int QW   = $clog2(QUEUE_DEPTH);
	localparam int FW   = $clog2(QUEUE_DEPTH + 1);
	localparam int AW   = $clog2(CLIENTS * QUEUE_DEPTH);
	localparam int RW   = 32;
	localparam int CSW  = 28;
	localparam int BW   = 17;

	typedef enum logic [3:0] {
		MODE_ADD    = 4'd0,
		MODE_REMOVE = 4'd1,
		MODE_RATE   = 4'd2,
		MODE_QUEUE  = 4'd3,
		MODE_EOS    = 4'd4,
		MODE_ACTIVE = 4'd5,
		MODE_TOKENS = 4'd6,
		MODE_SCHED  = 4'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_PARM  = 3'd1,
		ST_OP    = 3'd2,
		ST_EMPTY = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		R_EMIT, R_ADD, R_RATE, R_REMOVE, R_QUEUE, R_EOS, R_ACTIVE, R_TOKENS, R_SCHED
	} route_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_DECIDE, CMD_DIV_STEP, CMD_RATE_PREP, CMD_MUL, CMD_RATE_WR,
		CMD_ADD, CMD_REMOVE, CMD_QUEUE, CMD_EOS_RD, CMD_EOS_WR, CMD_ACTIVE,
		CMD_TOKENS, CMD_FIND, CMD_ADDC, CMD_LAST, CMD_MOVE, CMD_SUB, CMD_POP
	} cmd_t;

	typedef struct packed {
		cmd_t op;
		logic load;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		route_t route;
		logic   div_done;
		logic   elig;
		logic   find_end;
		logic   last_end;
		logic   found;
		logic   out_free;
	} dp_status_t;

	function automatic logic [QW-1:0] wrap_pos(input logic [QW:0] p);
		logic [QW:0] r;
		r = (int'(p) >= QUEUE_DEPTH) ? p - (QW+1)'(QUEUE_DEPTH) : p;
		return r[QW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [CIW-1:0] c,
		input logic [QW-1:0] pos);
		return AW'(int'(c) * QUEUE_DEPTH + int'(pos));
	endfunction

endpackage

/* rtl/core/weighted_fair_frame_scheduler.sv */
// Weighted fair frame scheduler: top level joining sequencer and datapath.
//
// One command item enters on the input channel (in_valid / in_stall) and
// yields exactly one result item on the output channel (out_valid /
// out_stall). Commands add, remove, retime, queue buffers, mark end of
// stream, suspend or resume a client, grant tokens, or schedule a frame.
// Items are handled one at a time; in_stall is high while one is in work.
// Add takes one 32-step restoring division, and set rate two in a shared
// divider plus one multiply; mark eos reads the buffer memory, then writes
// it. Schedule walks the list, one list entry visited per cycle. The
// sequencer returns to idle in the cycle after the result is loaded, and
// the next item is accepted from there.
// The result sits in an output register; the next item is accepted
// while it waits, but a second result holds in the sequencer until the
// register is taken. At reset no client exists, the list is empty and the
// output is idle; the buffer memory is not cleared.
module weighted_fair_frame_scheduler import wffs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic [2:0]  client,
	input  logic [15:0] fps_numerator,
	input  logic [15:0] fps_denominator,
	input  logic [15:0] buffer_tag,
	input  logic        at_tail,
	input  logic        active,
	input  logic [7:0]  token_grant,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [2:0]  chosen_client,
	output logic [15:0] buffer_tag_out,
	output logic        eos_out
);

	ctl_cmd_t   cmd;
	dp_status_t stat;

	wffs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	wffs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.mode            (mode),
		.client          (client),
		.fps_numerator   (fps_numerator),
		.fps_denominator (fps_denominator),
		.buffer_tag      (buffer_tag),
		.at_tail         (at_tail),
		.active          (active),
		.token_grant     (token_grant),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.status          (status),
		.chosen_client   (chosen_client),
		.buffer_tag_out  (buffer_tag_out),
		.eos_out         (eos_out)
	);

endmodule

/* rtl/core/wffs_ctrl.sv */
// Sequencer of the scheduler: walks each item through its datapath commands.
module wffs_ctrl import wffs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output ctl_cmd_t   cmd,
	input  dp_status_t stat
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_COST_DIV, S_RATE_PREP, S_RATE_DIV, S_MUL, S_EXEC,
		S_FIND, S_ADDC, S_LAST, S_MOVE, S_SUB, S_POP, S_EMIT
	} state_t;

	state_t state_q;
	cmd_t   op_q;
	route_t route_q;

	assign in_stall = (state_q != S_IDLE);
	assign cmd.op   = op_q;
	assign cmd.load = in_valid && (state_q == S_IDLE);
	assign cmd.emit = (state_q == S_EMIT) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= CMD_NONE;
			route_q <= R_EMIT;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
						op_q    <= CMD_DECIDE;
					end
				end
				S_DISPATCH: begin
					route_q <= stat.route;
					case (stat.route)
						R_ADD, R_RATE: begin
							state_q <= S_COST_DIV;
							op_q    <= CMD_DIV_STEP;
						end
						R_REMOVE: begin
							state_q <= S_EXEC;
							op_q    <= CMD_REMOVE;
						end
						R_QUEUE: begin
							state_q <= S_EXEC;
							op_q    <= CMD_QUEUE;
						end
						R_EOS: begin
							state_q <= S_EXEC;
							op_q    <= CMD_EOS_RD;
						end
						R_ACTIVE: begin
							state_q <= S_EXEC;
							op_q    <= CMD_ACTIVE;
						end
						R_TOKENS: begin
							state_q <= S_EXEC;
							op_q    <= CMD_TOKENS;
						end
						R_SCHED: begin
							state_q <= S_FIND;
							op_q    <= CMD_FIND;
						end
						default: begin
							state_q <= S_EMIT;
							op_q    <= CMD_NONE;
						end
					endcase
				end
				S_COST_DIV: begin
					if (stat.div_done) begin
						if (route_q == R_ADD) begin
							state_q <= S_EXEC;
							op_q    <= CMD_ADD;
						end else begin
							state_q <= S_RATE_PREP;
							op_q    <= CMD_RATE_PREP;
						end
					end
				end
				S_RATE_PREP: begin
					state_q <= S_RATE_DIV;
					op_q    <= CMD_DIV_STEP;
				end
				S_RATE_DIV: begin
					if (stat.div_done) begin
						state_q <= S_MUL;
						op_q    <= CMD_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_EXEC;
					op_q    <= CMD_RATE_WR;
				end
				S_EXEC: begin
					if (op_q == CMD_EOS_RD) begin
						op_q <= CMD_EOS_WR;
					end else begin
						state_q <= S_EMIT;
						op_q    <= CMD_NONE;
					end
				end
				S_FIND: begin
					if (stat.elig) begin
						state_q <= S_ADDC;
						op_q    <= CMD_ADDC;
					end else if (stat.find_end) begin
						state_q <= S_SUB;
						op_q    <= CMD_SUB;
					end
				end
				S_ADDC: begin
					state_q <= S_LAST;
					op_q    <= CMD_LAST;
				end
				S_LAST: begin
					if (stat.last_end) begin
						state_q <= S_MOVE;
						op_q    <= CMD_MOVE;
					end
				end
				S_MOVE: begin
					state_q <= S_SUB;
					op_q    <= CMD_SUB;
				end
				S_SUB: begin
					if (stat.found) begin
						state_q <= S_POP;
						op_q    <= CMD_POP;
					end else begin
						state_q <= S_EMIT;
						op_q    <= CMD_NONE;
					end
				end
				S_POP: begin
					state_q <= S_EMIT;
					op_q    <= CMD_NONE;
				end
				S_EMIT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						op_q    <= CMD_NONE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					op_q    <= CMD_NONE;
				end
			endcase
		end
	end

	a_load_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DISPATCH) && (op_q == CMD_DECIDE))
		else $error("accepted item not dispatched");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == S_IDLE))
		else $error("emit did not return to idle");
	a_pop_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> $past(stat.found))
		else $error("pop without a found client");

endmodule

/* rtl/core/wffs_datapath.sv */
// Client state, order list, buffer memory, divider and result register.
module wffs_datapath import wffs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_status_t  stat,
	input  logic [3:0]  mode,
	input  logic [2:0]  client,
	input  logic [15:0] fps_numerator,
	input  logic [15:0] fps_denominator,
	input  logic [15:0] buffer_tag,
	input  logic        at_tail,
	input  logic        active,
	input  logic [7:0]  token_grant,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [2:0]  chosen_client,
	output logic [15:0] buffer_tag_out,
	output logic        eos_out
);

	logic [3:0]  mode_q;
	logic [2:0]  cli_q;
	logic [15:0] num_q, den_q, tag_q;
	logic        tail_q, act_q;
	logic [7:0]  grant_q;

	logic [CLIENTS-1:0] exists_q, active_q;
	logic [CIW-1:0]     list_q   [CLIENTS];
	logic [CNTW-1:0]    count_q;
	logic [RW-1:0]      rounds_q [CLIENTS];
	logic [CSW-1:0]     cost_q   [CLIENTS];
	logic [7:0]         tokens_q [CLIENTS];
	logic [QW-1:0]      head_q   [CLIENTS];
	logic [FW-1:0]      fill_q   [CLIENTS];
	logic [BW-1:0]      mem_q    [CLIENTS*QUEUE_DEPTH];

	logic [RW-1:0]  dq_q;
	logic [CSW-1:0] rem_q, dv_q, nc_q;
	logic [4:0]     dcnt_q;
	logic [59:0]    prod_q;

	logic [RW-1:0]   adj_q, r_q;
	logic [CIW-1:0]  c_q, p_q, last_q;
	logic [CNTW-1:0] idx_q;
	logic            found_q;
	logic [AW-1:0]   addr_q;
	logic [BW-1:0]   rdata_q;

	status_t     res_st_q;
	logic [2:0]  res_c_q;
	logic [15:0] res_tag_q;
	logic        res_eos_q;
	logic        out_valid_q;
	status_t     out_st_q;
	logic [2:0]  out_c_q;
	logic [15:0] out_tag_q;
	logic        out_eos_q;

	logic [CIW-1:0] ci, rd_cli, fk;
	logic [RW-1:0]  rd_val, sum_r;
	logic [RW:0]    sum_w;
	logic           cli_ok, nd_zero, listed;
	status_t        pre_st;
	route_t         route;
	logic [CSW-1:0] cq, cdividend, old_cost;
	logic [CSW:0]   shifted, diff;
	logic           ge;
	logic           drop_hit;
	logic [CIW-1:0] drop_pos;
	logic [QW-1:0]  pos_tail, pos_head, pos_last;
	logic [8:0]     tok_sum;
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [BW-1:0]  mem_wdata;

	assign ci       = CIW'(cli_q);
	assign cli_ok   = int'(cli_q) < CLIENTS;
	assign nd_zero  = (num_q == 16'd0) || (den_q == 16'd0);
	assign listed   = active_q[ci];
	assign fk       = list_q[idx_q[CIW-1:0]];

	always_comb begin
		pre_st = ST_OK;
		route  = R_EMIT;
		if (mode_q > MODE_SCHED) begin
			pre_st = ST_OP;
		end else if (mode_q == MODE_SCHED) begin
			pre_st = ST_EMPTY;
			if (count_q != '0) route = R_SCHED;
		end else if (!cli_ok) begin
			pre_st = ST_PARM;
		end else if (mode_q == MODE_ADD) begin
			if (!exists_q[ci]) begin
				if (nd_zero) pre_st = ST_PARM;
				else route = R_ADD;
			end
		end else if (!exists_q[ci]) begin
			pre_st = ST_PARM;
		end else begin
			case (mode_q)
				MODE_REMOVE: begin
					if (fill_q[ci] != '0) pre_st = ST_OP;
					else route = R_REMOVE;
				end
				MODE_RATE: begin
					if (nd_zero) pre_st = ST_PARM;
					else route = R_RATE;
				end
				MODE_QUEUE: begin
					if (int'(fill_q[ci]) >= QUEUE_DEPTH) pre_st = ST_FULL;
					else route = R_QUEUE;
				end
				MODE_EOS: begin
					if (fill_q[ci] == '0) pre_st = ST_EMPTY;
					else route = R_EOS;
				end
				MODE_ACTIVE: route = R_ACTIVE;
				default:     route = R_TOKENS;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			CMD_DECIDE: rd_cli = list_q[0];
			CMD_ADDC:   rd_cli = c_q;
			CMD_LAST:   rd_cli = fk;
			default:    rd_cli = ci;
		endcase
	end
	assign rd_val = rounds_q[rd_cli];
	assign sum_w  = {1'b0, rd_val} + (RW+1)'(cost_q[c_q]);
	assign sum_r  = sum_w[RW] ? {RW{1'b1}} : sum_w[RW-1:0];

	assign cdividend = CSW'(32'(COST_UNIT) * 32'(den_q));
	assign cq        = (dq_q == '0) ? CSW'(1) : dq_q[CSW-1:0];
	assign old_cost  = (cost_q[ci] == '0) ? CSW'(1) : cost_q[ci];
	assign shifted   = {rem_q, dq_q[RW-1]};
	assign ge        = shifted >= {1'b0, dv_q};
	assign diff      = shifted - {1'b0, dv_q};
	assign tok_sum   = {1'b0, tokens_q[ci]} + {1'b0, grant_q};

	always_comb begin
		drop_hit = 1'b0;
		drop_pos = '0;
		for (int i = 0; i < CLIENTS; i++) begin
			if (!drop_hit && (i < int'(count_q)) && (list_q[i] == ci)) begin
				drop_hit = 1'b1;
				drop_pos = CIW'(i);
			end
		end
	end

	assign pos_tail = wrap_pos((QW+1)'(head_q[ci]) + (QW+1)'(fill_q[ci]));
	assign pos_head = (head_q[ci] == '0) ? QW'(QUEUE_DEPTH - 1) : head_q[ci] - QW'(1);
	assign pos_last = wrap_pos((QW+1)'(head_q[ci]) + (QW+1)'(fill_q[ci]) - (QW+1)'(1));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = rdata_q | {1'b1, 16'd0};
		mem_re    = 1'b0;
		mem_raddr = slot_addr(ci, pos_last);
		case (cmd.op)
			CMD_QUEUE: begin
				mem_we    = 1'b1;
				mem_waddr = slot_addr(ci, tail_q ? pos_tail : pos_head);
				mem_wdata = {1'b0, tag_q};
			end
			CMD_EOS_RD: mem_re = 1'b1;
			CMD_EOS_WR: mem_we = 1'b1;
			CMD_SUB: begin
				mem_re    = found_q;
				mem_raddr = slot_addr(c_q, head_q[c_q]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[mem_raddr];
	end

	// input capture, divider, schedule scratch and result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			cli_q   <= client;
			num_q   <= fps_numerator;
			den_q   <= fps_denominator;
			tag_q   <= buffer_tag;
			tail_q  <= at_tail;
			act_q   <= active;
			grant_q <= token_grant;
		end
		case (cmd.op)
			CMD_DECIDE: begin
				res_st_q  <= pre_st;
				res_c_q   <= 3'd0;
				res_tag_q <= 16'd0;
				res_eos_q <= 1'b0;
				adj_q     <= rd_val;
				idx_q     <= '0;
				found_q   <= 1'b0;
				dq_q      <= RW'(cdividend);
				rem_q     <= '0;
				dv_q      <= CSW'(num_q);
				dcnt_q    <= 5'(RW - 1);
			end
			CMD_DIV_STEP: begin
				rem_q  <= ge ? diff[CSW-1:0] : shifted[CSW-1:0];
				dq_q   <= {dq_q[RW-2:0], ge};
				dcnt_q <= dcnt_q - 5'd1;
			end
			CMD_RATE_PREP: begin
				nc_q   <= cq;
				dq_q   <= rd_val;
				rem_q  <= '0;
				dv_q   <= old_cost;
				dcnt_q <= 5'(RW - 1);
			end
			CMD_MUL: prod_q <= 60'(dq_q) * 60'(nc_q);
			CMD_EOS_RD: addr_q <= mem_raddr;
			CMD_FIND: begin
				if (tokens_q[fk] != 8'd0 && fill_q[fk] != '0) begin
					found_q <= 1'b1;
					c_q     <= fk;
					p_q     <= idx_q[CIW-1:0];
				end else begin
					idx_q <= idx_q + CNTW'(1);
				end
			end
			CMD_ADDC: begin
				r_q    <= sum_r;
				last_q <= p_q;
				idx_q  <= CNTW'(p_q) + CNTW'(1);
			end
			CMD_LAST: begin
				if (idx_q < count_q) begin
					if (r_q >= rd_val) last_q <= idx_q[CIW-1:0];
					idx_q <= idx_q + CNTW'(1);
				end
			end
			CMD_POP: begin
				res_st_q  <= ST_OK;
				res_c_q   <= 3'(c_q);
				res_tag_q <= rdata_q[15:0];
				res_eos_q <= rdata_q[16];
			end
			default: ;
		endcase
		if (cmd.emit) begin
			out_st_q  <= res_st_q;
			out_c_q   <= res_c_q;
			out_tag_q <= res_tag_q;
			out_eos_q <= res_eos_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_ADD: begin
				for (int i = CLIENTS - 1; i > 0; i--) list_q[i] <= list_q[i-1];
				list_q[0] <= ci;
			end
			CMD_ACTIVE: begin
				if (act_q && !listed) begin
					for (int i = CLIENTS - 1; i > 0; i--) list_q[i] <= list_q[i-1];
					list_q[0] <= ci;
				end else if (!act_q && listed && drop_hit) begin
					for (int i = 0; i < CLIENTS - 1; i++)
						if (i >= int'(drop_pos)) list_q[i] <= list_q[i+1];
				end
			end
			CMD_REMOVE: begin
				if (drop_hit) begin
					for (int i = 0; i < CLIENTS - 1; i++)
						if (i >= int'(drop_pos)) list_q[i] <= list_q[i+1];
				end
			end
			CMD_MOVE: begin
				for (int i = 0; i < CLIENTS - 1; i++)
					if (i >= int'(p_q) && i < int'(last_q)) list_q[i] <= list_q[i+1];
				list_q[last_q] <= c_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exists_q    <= '0;
			active_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < CLIENTS; k++) begin
				rounds_q[k] <= '0;
				cost_q[k]   <= '0;
				tokens_q[k] <= '0;
				head_q[k]   <= '0;
				fill_q[k]   <= '0;
			end
		end else begin
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (cmd.op)
				CMD_ADD: begin
					exists_q[ci] <= 1'b1;
					active_q[ci] <= 1'b1;
					tokens_q[ci] <= '0;
					head_q[ci]   <= '0;
					fill_q[ci]   <= '0;
					cost_q[ci]   <= cq;
					rounds_q[ci] <= (count_q != '0) ? adj_q : '0;
					count_q      <= count_q + CNTW'(1);
				end
				CMD_ACTIVE: begin
					active_q[ci] <= act_q;
					if (act_q && !listed) begin
						rounds_q[ci] <= (count_q != '0) ? adj_q : '0;
						count_q      <= count_q + CNTW'(1);
					end else if (!act_q && listed && drop_hit) begin
						count_q <= count_q - CNTW'(1);
					end
				end
				CMD_REMOVE: begin
					if (drop_hit) count_q <= count_q - CNTW'(1);
					exists_q[ci] <= 1'b0;
					active_q[ci] <= 1'b0;
					rounds_q[ci] <= '0;
					cost_q[ci]   <= '0;
					tokens_q[ci] <= '0;
					head_q[ci]   <= '0;
				end
				CMD_RATE_WR: begin
					rounds_q[ci] <= (prod_q[59:RW] != '0) ? {RW{1'b1}} : prod_q[RW-1:0];
					cost_q[ci]   <= nc_q;
				end
				CMD_QUEUE: begin
					if (!tail_q) head_q[ci] <= pos_head;
					fill_q[ci] <= fill_q[ci] + FW'(1);
				end
				CMD_TOKENS: tokens_q[ci] <= tok_sum[8] ? 8'hFF : tok_sum[7:0];
				CMD_ADDC:   rounds_q[c_q] <= sum_r;
				CMD_SUB: begin
					for (int k = 0; k < CLIENTS; k++)
						if (exists_q[k] && active_q[k])
							rounds_q[k] <= (rounds_q[k] < adj_q) ? '0 : rounds_q[k] - adj_q;
					if (found_q) begin
						head_q[c_q]   <= wrap_pos((QW+1)'(head_q[c_q]) + (QW+1)'(1));
						fill_q[c_q]   <= fill_q[c_q] - FW'(1);
						tokens_q[c_q] <= tokens_q[c_q] - 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.route    = route;
	assign stat.div_done = (dcnt_q == 5'd0);
	assign stat.elig     = (tokens_q[fk] != 8'd0) && (fill_q[fk] != '0);
	assign stat.find_end = (idx_q == count_q - CNTW'(1));
	assign stat.last_end = (idx_q >= count_q);
	assign stat.found    = found_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign status         = out_st_q;
	assign chosen_client  = out_c_q;
	assign buffer_tag_out = out_tag_q;
	assign eos_out        = out_eos_q;

	a_count_listed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(exists_q & active_q) == int'(count_q))
		else $error("order count disagrees with listed clients");
	a_active_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q & ~exists_q) == '0)
		else $error("active client that does not exist");
	a_head_listed: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (exists_q[list_q[0]] && active_q[list_q[0]]))
		else $error("list head is not a listed client");

endmodule

/* test/weighted_fair_frame_scheduler_tb.sv */
// Testbench of the weighted fair frame scheduler: directed corners and random commands checked against a predictor.
module weighted_fair_frame_scheduler_tb import wffs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [3:0]  mode;
		logic [2:0]  client;
		logic [15:0] num;
		logic [15:0] den;
		logic [15:0] tag;
		logic        tail;
		logic        act;
		logic [7:0]  grant;
	} cmd_item_t;

	typedef struct {
		status_t     st;
		logic [2:0]  who;
		logic [15:0] tag;
		logic        eos;
	} sched_result_t;

	class frame_sched_board;
		bit            exists[CLIENTS];
		bit            running[CLIENTS];
		logic [2:0]    order[CLIENTS];
		int unsigned   order_len;
		logic [31:0]   vtime[CLIENTS];
		logic [31:0]   cost[CLIENTS];
		int unsigned   credit[CLIENTS];
		logic [16:0]   bufs[CLIENTS*QUEUE_DEPTH];
		int unsigned   qhead[CLIENTS];
		int unsigned   qfill[CLIENTS];
		sched_result_t pending[$];
		int unsigned   errors;
		int unsigned   checked;
		int unsigned   sched_ok;

		function int find_pos(int unsigned c);
			for (int i = 0; i < order_len; i++)
				if (order[i] == c) return i;
			return -1;
		endfunction

		function void drop(int unsigned c);
			int p;
			p = find_pos(c);
			if (p < 0) return;
			for (int i = p; i + 1 < order_len; i++) order[i] = order[i+1];
			order_len--;
		endfunction

		function void push_front(int unsigned c);
			if (find_pos(c) >= 0 || order_len >= CLIENTS) return;
			vtime[c] = order_len ? vtime[order[0]] : 32'd0;
			for (int i = order_len; i > 0; i--) order[i] = order[i-1];
			order[0] = 3'(c);
			order_len++;
		endfunction

		function logic [31:0] frame_cost_of(logic [15:0] n, logic [15:0] d);
			logic [31:0] q;
			q = (32'd3600 * d) / n;
			return q ? q : 32'd1;
		endfunction

		function sched_result_t pick(sched_result_t r);
			int unsigned adj, p, last, c, k;
			logic [32:0] sum;
			bit hit;
			hit = 0; c = 0; p = 0;
			if (order_len == 0) begin
				r.st = ST_EMPTY;
				return r;
			end
			adj = vtime[order[0]];
			for (int i = 0; i < order_len; i++) begin
				k = order[i];
				if (!hit && credit[k] && qfill[k]) begin
					hit = 1; c = k; p = i;
				end
			end
			if (hit) begin
				sum = {1'b0, vtime[c]} + cost[c];
				vtime[c] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				last = p;
				for (int q = p + 1; q < order_len; q++)
					if (vtime[c] >= vtime[order[q]]) last = q;
				for (int q = p; q < last; q++) order[q] = order[q+1];
				order[last] = 3'(c);
			end
			for (int i = 0; i < order_len; i++) begin
				k = order[i];
				vtime[k] = vtime[k] < adj ? 32'd0 : vtime[k] - adj;
			end
			if (!hit) begin
				r.st = ST_EMPTY;
				return r;
			end
			r.who = 3'(c);
			r.tag = bufs[c*QUEUE_DEPTH + qhead[c]][15:0];
			r.eos = bufs[c*QUEUE_DEPTH + qhead[c]][16];
			qhead[c] = (qhead[c] + 1) % QUEUE_DEPTH;
			qfill[c]--;
			credit[c]--;
			sched_sok_bump();
			return r;
		endfunction

		function void sched_sok_bump();
			sched_ok++;
		endfunction

		function void note_command(cmd_item_t x);
			sched_result_t r;
			int unsigned c, pos;
			logic [31:0] oc, nc;
			logic [63:0] v;
			r = '{ST_OK, 3'd0, 16'd0, 1'b0};
			c = x.client;
			if (x.mode > MODE_SCHED) r.st = ST_OP;
			else if (x.mode == MODE_SCHED) r = pick(r);
			else if (x.mode == MODE_ADD) begin
				if (!exists[c]) begin
					if (x.num == 0 || x.den == 0) r.st = ST_PARM;
					else begin
						exists[c] = 1; running[c] = 1; credit[c] = 0;
						qhead[c] = 0; qfill[c] = 0;
						cost[c] = frame_cost_of(x.num, x.den);
						push_front(c);
					end
				end
			end else if (!exists[c]) r.st = ST_PARM;
			else case (x.mode)
				MODE_REMOVE: begin
					if (qfill[c]) r.st = ST_OP;
					else begin
						drop(c);
						exists[c] = 0; running[c] = 0; vtime[c] = 0;
						cost[c] = 0; credit[c] = 0; qhead[c] = 0;
					end
				end
				MODE_RATE: begin
					if (x.num == 0 || x.den == 0) r.st = ST_PARM;
					else begin
						oc = cost[c] ? cost[c] : 32'd1;
						nc = frame_cost_of(x.num, x.den);
						v = 64'(vtime[c] / oc) * nc;
						vtime[c] = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
						cost[c] = nc;
					end
				end
				MODE_QUEUE: begin
					if (qfill[c] >= QUEUE_DEPTH) r.st = ST_FULL;
					else begin
						if (x.tail) pos = (qhead[c] + qfill[c]) % QUEUE_DEPTH;
						else begin
							pos = qhead[c] ? qhead[c] - 1 : QUEUE_DEPTH - 1;
							qhead[c] = pos;
						end
						bufs[c*QUEUE_DEPTH + pos] = {1'b0, x.tag};
						qfill[c]++;
					end
				end
				MODE_EOS: begin
					if (qfill[c] == 0) r.st = ST_EMPTY;
					else begin
						pos = (qhead[c] + qfill[c] - 1) % QUEUE_DEPTH;
						bufs[c*QUEUE_DEPTH + pos][16] = 1'b1;
					end
				end
				MODE_ACTIVE: begin
					if (x.act != running[c]) begin
						running[c] = x.act;
						if (x.act) push_front(c);
						else drop(c);
					end
				end
				default: credit[c] = credit[c] + x.grant > 255 ? 255 : credit[c] + x.grant;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result status %0d", got.st);
				return;
			end
			e = pending.pop_front();
			if (got.st !== e.st || got.who !== e.who || got.tag !== e.tag ||
					got.eos !== e.eos) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch #%0d: exp st=%0d cl=%0d tag=%h eos=%b",
						" got st=%0d cl=%0d tag=%h eos=%b"},
						checked, e.st, e.who, e.tag, e.eos,
						got.st, got.who, got.tag, got.eos);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [3:0]  mode = 0;
	logic [2:0]  client = 0;
	logic [15:0] fps_numerator = 0;
	logic [15:0] fps_denominator = 0;
	logic [15:0] buffer_tag = 0;
	logic        at_tail = 0;
	logic        active = 0;
	logic [7:0]  token_grant = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [2:0]  chosen_client;
	logic [15:0] buffer_tag_out;
	logic        eos_out;

	frame_sched_board board = new();
	int unsigned idle_cycles = 0;
	bit          stim_done = 0;
	int unsigned sent = 0;
	localparam int unsigned WATCHDOG = 2000;

	weighted_fair_frame_scheduler u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task automatic send(cmd_item_t x);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		repeat (gap + 1) @(negedge clk);
		mode <= x.mode; client <= x.client;
		fps_numerator <= x.num; fps_denominator <= x.den;
		buffer_tag <= x.tag; at_tail <= x.tail; active <= x.act;
		token_grant <= x.grant;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		board.note_command(x);
		sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	function automatic cmd_item_t mk(mode_t m, int c);
		cmd_item_t x;
		x.mode = m; x.client = 3'(c);
		x.num = 16'($urandom_range(1, 60)); x.den = 16'($urandom_range(1, 2));
		x.tag = 16'($urandom); x.tail = 1'($urandom); x.act = 1'($urandom);
		x.grant = 8'($urandom_range(1, 8));
		return x;
	endfunction

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	// receiver: random stall per result
	initial begin
		sched_result_t g;
		int unsigned hold;
		forever begin
			hold = $urandom_range(0, 3);
			if (hold != 0) begin
				@(negedge clk);
				out_stall <= 1;
				repeat (hold) @(negedge clk);
				out_stall <= 0;
			end
			do @(posedge clk); while (!out_valid);
			g.st = status_t'(status); g.who = chosen_client;
			g.tag = buffer_tag_out; g.eos = eos_out;
			board.check_result(g);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !stim_done) begin
			$display("watchdog timeout");
			$display("[weighted_fair_frame_scheduler] ERROR");
			$finish;
		end
	end

	initial begin
		cmd_item_t x;
		int r;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed corners
		x = mk(MODE_SCHED, 0); send(x);
		x = mk(MODE_QUEUE, 2); send(x);
		x = mk(MODE_ADD, 1); x.num = 0; send(x);
		x = mk(MODE_ADD, 1); x.den = 0; send(x);
		x = mk(MODE_ADD, 1); x.num = 16'hFFFF; x.den = 16'h0001; send(x);
		x = mk(MODE_ADD, 1); send(x);
		x = mk(MODE_ADD, 6); x.num = 16'h0001; x.den = 16'hFFFF; send(x);
		x = mk(MODE_SCHED, 0); send(x);
		x = mk(MODE_EOS, 1); send(x);
		x = mk(MODE_TOKENS, 1); x.grant = 8'hFF; send(x);
		send(x);
		for (int i = 0; i < 17; i++) begin
			x = mk(MODE_QUEUE, 6); x.tag = i[0] ? 16'hFFFF : 16'h0000; send(x);
		end
		x = mk(MODE_EOS, 6); send(x);
		x = mk(MODE_TOKENS, 6); x.grant = 3; send(x);
		x = mk(MODE_RATE, 6); x.num = 0; send(x);
		x = mk(MODE_RATE, 6); x.num = 16'hFFFF; x.den = 16'hFFFF; send(x);
		x = mk(MODE_REMOVE, 6); send(x);
		for (int i = 0; i < 4; i++) begin x = mk(MODE_SCHED, 0); send(x); end
		x = mk(MODE_ACTIVE, 1); x.act = 0; send(x);
		x = mk(MODE_ACTIVE, 1); x.act = 1; send(x);
		x = mk(MODE_REMOVE, 1); send(x);
		x.mode = 4'd8; send(x);
		x.mode = 4'd15; send(x);
		drain();
		// random traffic biased to build populated queues and schedules
		while (sent < 1230) begin
			r = $urandom_range(0, 99);
			if (r < 8) x = mk(MODE_ADD, $urandom_range(0, 7));
			else if (r < 11) x = mk(MODE_REMOVE, $urandom_range(0, 7));
			else if (r < 15) x = mk(MODE_RATE, $urandom_range(0, 7));
			else if (r < 40) x = mk(MODE_QUEUE, $urandom_range(0, 7));
			else if (r < 45) x = mk(MODE_EOS, $urandom_range(0, 7));
			else if (r < 50) x = mk(MODE_ACTIVE, $urandom_range(0, 7));
			else if (r < 62) x = mk(MODE_TOKENS, $urandom_range(0, 7));
			else if (r < 96) x = mk(MODE_SCHED, $urandom_range(0, 7));
			else begin
				x = mk(MODE_SCHED, $urandom_range(0, 7));
				x.mode = 4'($urandom_range(8, 15));
			end
			if ($urandom_range(0, 19) == 0) begin
				x.num = 16'($urandom); x.den = 16'($urandom); x.grant = 8'($urandom);
			end
			send(x);
			if (sent % 400 == 0) drain();
		end
		stim_done = 1;
		drain();
		repeat (100) @(posedge clk);
		$display("sent %0d commands, checked %0d results, %0d frames scheduled",
			sent, board.checked, board.sched_ok);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[weighted_fair_frame_scheduler] OK");
		else
			$display("[weighted_fair_frame_scheduler] ERROR");
		$finish;
	end

	// bound the final drain as well
	initial begin
		wait (stim_done);
		repeat (20000) @(posedge clk);
		$display("drain timeout");
		$display("[weighted_fair_frame_scheduler] ERROR");
		$finish;
	end
endmodule
